>>> src/cfc_pkg.sv
// cfc_pkg: shared constants, types and the preload table for the csi fifo fill block
// used by cfc_front, cfc_mid_queue, cfc_back, cfc_rsp_queue and csi_fifo_fill_calc
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package cfc_pkg;

   // link framing constants
   localparam int HDR_BYTES    = 4;
   localparam int FTR_BYTES    = 2;
   localparam int PRELOAD_N    = 15;
   localparam int FRAC_SCALE   = 50;
   localparam int FRAC_OFFSET  = 3;
   localparam int PRELOAD_BASE = 7;
   localparam int X_SCALE      = FRAC_SCALE * 4;

   // datapath widths
   localparam int DIV_W  = 37;   // ceiling-adjusted magnitude
   localparam int MAG_W  = 36;
   localparam int X_W    = 23;   // divisor 200 * pclk * unit
   localparam int QUO_W  = 16;   // quotient bits kept after the overflow check
   localparam int UNIT_W = 5;
   localparam int FILL_W = QUO_W + UNIT_W;

   // queue sizes
   localparam int MID_DEPTH = 8;
   localparam int MID_PTR_W = 3;
   localparam int MID_CNT_W = 4;
   localparam int RSP_DEPTH = 32;
   localparam int RSP_PTR_W = 5;
   localparam int RSP_CNT_W = 6;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_INVALID  = 2'd1,
      STATUS_OVERFLOW = 2'd2
   } status_type;

   // word handed from the front end to the divider
   typedef struct packed {
      logic [DIV_W-1:0]  dividend;
      logic [X_W-1:0]    x;
      logic [UNIT_W-1:0] unit;
      logic              positive;
      logic              invalid;
   } work_type;

   // one divider stage
   typedef struct packed {
      logic              valid;
      logic [X_W-1:0]    rem;
      logic [QUO_W-1:0]  low;
      logic [QUO_W-1:0]  quo;
      logic [X_W-1:0]    x;
      logic [UNIT_W-1:0] unit;
      logic              positive;
      logic              invalid;
      logic              ovf;
   } div_stage_type;

   // result word
   typedef struct packed {
      status_type  status;
      logic [15:0] rx_fill;
      logic [15:0] tx_fill;
   } result_type;

   // preload term 7 + 60 / lanes
   function automatic logic [6:0] preload_q(input logic [3:0] lanes);
      logic [6:0] q;
      case (lanes)
         4'd1:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 1);
         4'd2:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 2);
         4'd3:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 3);
         4'd4:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 4);
         4'd5:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 5);
         4'd6:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 6);
         4'd7:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 7);
         4'd8:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 8);
         4'd9:    q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 9);
         4'd10:   q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 10);
         4'd11:   q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 11);
         4'd12:   q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 12);
         4'd13:   q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 13);
         4'd14:   q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 14);
         4'd15:   q = 7'(PRELOAD_BASE + (PRELOAD_N * 4) / 15);
         default: q = 7'(PRELOAD_BASE);   // zero lanes, flagged invalid anyway
      endcase
      return q;
   endfunction

endpackage
`default_nettype wire

>>> src/cfc_front.sv
// cfc_front: five-stage pipeline that checks the link parameters and forms
// the ceiling-adjusted line-time difference and the fill divisor
// depends on cfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module cfc_front (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   input  wire logic [12:0]           lane_bitrate_mhz,
   input  wire logic [3:0]            lane_count,
   input  wire logic [5:0]            bits_per_pixel,
   input  wire logic [15:0]           line_pixels,
   input  wire logic [9:0]            pixel_clock_mhz,
   output      logic                  out_valid,
   output      cfc_pkg::work_type     out_work
);

   // stage 1: byte clock, unit, line bytes, lane product, line plus preload
   logic [9:0]  bclk_c;
   logic [4:0]  unit_c;
   logic [21:0] line_bits_c;
   logic        s1_valid_ff;
   logic [18:0] s1_a_ff, s1_a_in;
   logic [13:0] s1_d_ff, s1_d_in;
   logic [16:0] s1_lq_ff, s1_lq_in;
   logic [9:0]  s1_pclk_ff;
   logic [4:0]  s1_unit_ff;
   logic        s1_inv_ff, s1_inv_in;

   assign bclk_c      = lane_bitrate_mhz[12:3];
   assign unit_c      = bits_per_pixel[5:1];
   assign line_bits_c = 22'(line_pixels) * 22'(bits_per_pixel);
   assign s1_a_in     = 19'(line_bits_c >> 3) + 19'(cfc_pkg::HDR_BYTES + cfc_pkg::FTR_BYTES);
   assign s1_d_in     = 14'(lane_count) * 14'(bclk_c);
   assign s1_lq_in    = 17'(line_pixels) + 17'(cfc_pkg::preload_q(lane_count));
   assign s1_inv_in   = (lane_count == 4'd0) || (pixel_clock_mhz == 10'd0) ||
                        (bclk_c == 10'd0) || (unit_c == 5'd0);

   // stage 2: products with the pixel clock and the lane term
   logic        s2_valid_ff;
   logic [28:0] s2_ap_ff, s2_ap_in;
   logic [23:0] s2_dp_ff, s2_dp_in;
   logic [29:0] s2_lqd_ff, s2_lqd_in;
   logic [14:0] s2_pu_ff, s2_pu_in;
   logic [4:0]  s2_unit_ff;
   logic        s2_inv_ff;

   assign s2_ap_in  = 29'(s1_a_ff) * 29'(s1_pclk_ff);
   assign s2_dp_in  = 24'(s1_d_ff) * 24'(s1_pclk_ff);
   assign s2_lqd_in = 30'(s1_lq_ff) * 30'(s1_d_ff);
   assign s2_pu_in  = 15'(s1_pclk_ff) * 15'(s1_unit_ff);

   // stage 3: scale by the fixed fractions
   logic                      s3_valid_ff;
   logic [cfc_pkg::MAG_W-1:0] s3_pos_ff, s3_pos_in;
   logic [cfc_pkg::MAG_W-1:0] s3_neg_ff, s3_neg_in;
   logic [cfc_pkg::X_W-1:0]   s3_x_ff, s3_x_in;
   logic [4:0]                s3_unit_ff;
   logic                      s3_inv_ff;

   assign s3_pos_in = cfc_pkg::MAG_W'(s2_ap_ff) * cfc_pkg::MAG_W'(cfc_pkg::FRAC_SCALE) +
                      cfc_pkg::MAG_W'(s2_dp_ff) * cfc_pkg::MAG_W'(cfc_pkg::FRAC_OFFSET);
   assign s3_neg_in = cfc_pkg::MAG_W'(s2_lqd_ff) * cfc_pkg::MAG_W'(cfc_pkg::FRAC_SCALE);
   assign s3_x_in   = cfc_pkg::X_W'(s2_pu_ff) * cfc_pkg::X_W'(cfc_pkg::X_SCALE);

   // stage 4: sign and magnitude of the difference
   logic                      s4_valid_ff;
   logic [cfc_pkg::MAG_W-1:0] s4_mag_ff, s4_mag_in;
   logic                      s4_pos_ff, s4_pos_in;
   logic [cfc_pkg::X_W-1:0]   s4_x_ff;
   logic [4:0]                s4_unit_ff;
   logic                      s4_inv_ff;

   assign s4_pos_in = s3_pos_ff > s3_neg_ff;
   assign s4_mag_in = s4_pos_in ? (s3_pos_ff - s3_neg_ff) : (s3_neg_ff - s3_pos_ff);

   // stage 5: ceiling adjustment
   logic              s5_valid_ff;
   cfc_pkg::work_type s5_work_ff, s5_work_in;

   always_comb begin
      s5_work_in.dividend = cfc_pkg::DIV_W'(s4_mag_ff) + cfc_pkg::DIV_W'(s4_x_ff) -
                            cfc_pkg::DIV_W'(1);
      s5_work_in.x        = s4_x_ff;
      s5_work_in.unit     = s4_unit_ff;
      s5_work_in.positive = s4_pos_ff;
      s5_work_in.invalid  = s4_inv_ff;
   end

   // valid chain
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
         s5_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
         s5_valid_ff <= s4_valid_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      s1_a_ff    <= s1_a_in;
      s1_d_ff    <= s1_d_in;
      s1_lq_ff   <= s1_lq_in;
      s1_pclk_ff <= pixel_clock_mhz;
      s1_unit_ff <= unit_c;
      s1_inv_ff  <= s1_inv_in;
      s2_ap_ff   <= s2_ap_in;
      s2_dp_ff   <= s2_dp_in;
      s2_lqd_ff  <= s2_lqd_in;
      s2_pu_ff   <= s2_pu_in;
      s2_unit_ff <= s1_unit_ff;
      s2_inv_ff  <= s1_inv_ff;
      s3_pos_ff  <= s3_pos_in;
      s3_neg_ff  <= s3_neg_in;
      s3_x_ff    <= s3_x_in;
      s3_unit_ff <= s2_unit_ff;
      s3_inv_ff  <= s2_inv_ff;
      s4_mag_ff  <= s4_mag_in;
      s4_pos_ff  <= s4_pos_in;
      s4_x_ff    <= s3_x_ff;
      s4_unit_ff <= s3_unit_ff;
      s4_inv_ff  <= s3_inv_ff;
      s5_work_ff <= s5_work_in;
   end

   assign out_valid = s5_valid_ff;
   assign out_work  = s5_work_ff;

endmodule
`default_nettype wire

>>> src/cfc_mid_queue.sv
// cfc_mid_queue: small queue of work words between the front end and the divider
// depends on cfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module cfc_mid_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire cfc_pkg::work_type push_data,
   input  wire logic              pop,
   output      logic              empty,
   output      cfc_pkg::work_type head
);

   cfc_pkg::work_type              mem_ff [cfc_pkg::MID_DEPTH];
   logic [cfc_pkg::MID_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cfc_pkg::MID_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cfc_pkg::MID_CNT_W-1:0]  count_ff, count_in;
   logic                           do_pop;

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + cfc_pkg::MID_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + cfc_pkg::MID_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + cfc_pkg::MID_CNT_W'(push) - cfc_pkg::MID_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> src/cfc_back.sv
// cfc_back: pipelined restoring divider (one quotient bit per stage), fill
// scaling and status encoding
// depends on cfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module cfc_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                in_valid,
   input  wire cfc_pkg::work_type   in_work,
   output      logic                out_valid,
   output      cfc_pkg::result_type out_result
);

   localparam int QW = cfc_pkg::QUO_W;
   localparam int XW = cfc_pkg::X_W;

   cfc_pkg::div_stage_type stg_ff [QW+1];
   cfc_pkg::div_stage_type stg_in [QW+1];

   // entry: upper dividend bits decide overflow, lower bits feed the stages
   logic [cfc_pkg::DIV_W-QW-1:0] hi_c;
   logic                         ovf_c;

   assign hi_c  = in_work.dividend[cfc_pkg::DIV_W-1:QW];
   assign ovf_c = {2'b00, hi_c} >= in_work.x;

   always_comb begin
      stg_in[0].valid    = in_valid;
      stg_in[0].rem      = ovf_c ? '0 : XW'(hi_c);
      stg_in[0].low      = in_work.dividend[QW-1:0];
      stg_in[0].quo      = '0;
      stg_in[0].x        = in_work.x;
      stg_in[0].unit     = in_work.unit;
      stg_in[0].positive = in_work.positive;
      stg_in[0].invalid  = in_work.invalid;
      stg_in[0].ovf      = ovf_c;
   end

   // one compare and subtract per stage
   for (genvar k = 0; k < QW; k++) begin : g_step
      logic [XW:0] trial;
      logic        ge;

      assign trial = {stg_ff[k].rem, stg_ff[k].low[QW-1]};
      assign ge    = trial >= {1'b0, stg_ff[k].x};

      always_comb begin
         stg_in[k+1]     = stg_ff[k];
         stg_in[k+1].rem = ge ? XW'(trial - {1'b0, stg_ff[k].x}) : trial[XW-1:0];
         stg_in[k+1].low = {stg_ff[k].low[QW-2:0], 1'b0};
         stg_in[k+1].quo = {stg_ff[k].quo[QW-2:0], ge};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k <= QW; k++) begin
            stg_ff[k].valid <= 1'b0;
         end
      end else begin
         stg_ff <= stg_in;
      end
   end

   // fill = quotient times unit
   logic                        mul_valid_ff;
   logic [cfc_pkg::FILL_W-1:0]  fill_ff, fill_in;
   logic                        mul_pos_ff, mul_inv_ff, mul_ovf_ff;

   assign fill_in = cfc_pkg::FILL_W'(stg_ff[QW].quo) * cfc_pkg::FILL_W'(stg_ff[QW].unit);

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= stg_ff[QW].valid;
      end
   end

   always_ff @(posedge clock) begin
      fill_ff    <= fill_in;
      mul_pos_ff <= stg_ff[QW].positive;
      mul_inv_ff <= stg_ff[QW].invalid;
      mul_ovf_ff <= stg_ff[QW].ovf;
   end

   // status and routing of the fill
   logic too_big_c;

   assign too_big_c = mul_ovf_ff || (|fill_ff[cfc_pkg::FILL_W-1:16]);

   always_comb begin
      out_result.rx_fill = '0;
      out_result.tx_fill = '0;
      if (mul_inv_ff) begin
         out_result.status = cfc_pkg::STATUS_INVALID;
      end else if (too_big_c) begin
         out_result.status = cfc_pkg::STATUS_OVERFLOW;
      end else begin
         out_result.status = cfc_pkg::STATUS_OK;
         if (mul_pos_ff) begin
            out_result.rx_fill = fill_ff[15:0];
         end else begin
            out_result.tx_fill = fill_ff[15:0];
         end
      end
   end

   assign out_valid = mul_valid_ff;

endmodule
`default_nettype wire

>>> src/cfc_rsp_queue.sv
// cfc_rsp_queue: result queue in front of the result ports
// depends on cfc_pkg
`timescale 1ns / 1ps
`default_nettype none
module cfc_rsp_queue (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                push,
   input  wire cfc_pkg::result_type push_data,
   input  wire logic                pop,
   output      logic                empty,
   output      cfc_pkg::result_type head
);

   cfc_pkg::result_type            mem_ff [cfc_pkg::RSP_DEPTH];
   logic [cfc_pkg::RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [cfc_pkg::RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [cfc_pkg::RSP_CNT_W-1:0]  count_ff, count_in;
   logic                           do_pop;

   assign empty  = (count_ff == '0);
   assign do_pop = pop && !empty;
   assign head   = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + cfc_pkg::RSP_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + cfc_pkg::RSP_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + cfc_pkg::RSP_CNT_W'(push) - cfc_pkg::RSP_CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

>>> src/csi_fifo_fill_calc.sv
// csi_fifo_fill_calc: fifo fill level for a csi receive/transmit link
// depends on cfc_pkg, cfc_front, cfc_mid_queue, cfc_back, cfc_rsp_queue
//
// Usage: one link configuration per input word, one result word out.
// Input side is a queue write port: a word is taken on a rising edge with
// push high and full low. Result side is a queue read port: the oldest
// result sits on rsp_* while empty is low and leaves on a rising edge with
// pop high.
// Path: from the accepting edge to empty going low the word is registered in
// turn in the five front stages, the middle queue write, the divider entry,
// the sixteen divider stages, the fill multiply and the result queue write.
// Throughput: one word per cycle, sustained while the receiver pops every cycle.
// The front end and the divider run freely; each sends words into a queue
// only against free slots (8 in the middle queue, 32 in the result queue),
// counted with everything in flight. When the receiver stops popping, the
// result queue fills, the divider stops drawing from the middle queue and
// full rises once all middle queue slots are counted; nothing is dropped.
// Reset empties both queues and the pipelines; results follow in input order.
`timescale 1ns / 1ps
`default_nettype none
module csi_fifo_fill_calc (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output      logic        full,
   input  wire logic [12:0] req_lane_bitrate_mhz,
   input  wire logic [3:0]  req_lane_count,
   input  wire logic [5:0]  req_bits_per_pixel,
   input  wire logic [15:0] req_line_pixels,
   input  wire logic [9:0]  req_pixel_clock_mhz,
   output      logic        empty,
   input  wire logic        pop,
   output      logic [1:0]  rsp_status,
   output      logic [15:0] rsp_rx_fill,
   output      logic [15:0] rsp_tx_fill
);

   logic                          accept;
   logic                          front_valid;
   cfc_pkg::work_type             front_work;
   logic                          mid_empty;
   logic                          mid_pop;
   cfc_pkg::work_type             mid_head;
   logic                          back_valid;
   cfc_pkg::result_type           back_result;
   cfc_pkg::result_type           rsp_head;
   logic                          rsp_take;
   logic [cfc_pkg::MID_CNT_W-1:0] front_cnt_ff, front_cnt_in;
   logic [cfc_pkg::RSP_CNT_W-1:0] back_cnt_ff, back_cnt_in;

   // slot accounting on both sides of the middle queue
   assign full     = (front_cnt_ff == cfc_pkg::MID_CNT_W'(cfc_pkg::MID_DEPTH));
   assign accept   = push && !full;
   assign mid_pop  = !mid_empty && (back_cnt_ff < cfc_pkg::RSP_CNT_W'(cfc_pkg::RSP_DEPTH));
   assign rsp_take = pop && !empty;

   always_comb begin
      front_cnt_in = front_cnt_ff + cfc_pkg::MID_CNT_W'(accept) -
                     cfc_pkg::MID_CNT_W'(mid_pop);
      back_cnt_in  = back_cnt_ff + cfc_pkg::RSP_CNT_W'(mid_pop) -
                     cfc_pkg::RSP_CNT_W'(rsp_take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         front_cnt_ff <= '0;
         back_cnt_ff  <= '0;
      end else begin
         front_cnt_ff <= front_cnt_in;
         back_cnt_ff  <= back_cnt_in;
      end
   end

   // front end
   cfc_front u_front (
      .clock            (clock),
      .reset            (reset),
      .in_valid         (accept),
      .lane_bitrate_mhz (req_lane_bitrate_mhz),
      .lane_count       (req_lane_count),
      .bits_per_pixel   (req_bits_per_pixel),
      .line_pixels      (req_line_pixels),
      .pixel_clock_mhz  (req_pixel_clock_mhz),
      .out_valid        (front_valid),
      .out_work         (front_work)
   );

   // middle queue
   cfc_mid_queue u_mid_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (front_valid),
      .push_data (front_work),
      .pop       (mid_pop),
      .empty     (mid_empty),
      .head      (mid_head)
   );

   // divider and result encoding
   cfc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (mid_pop),
      .in_work    (mid_head),
      .out_valid  (back_valid),
      .out_result (back_result)
   );

   // result queue
   cfc_rsp_queue u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (back_valid),
      .push_data (back_result),
      .pop       (pop),
      .empty     (empty),
      .head      (rsp_head)
   );

   assign rsp_status  = rsp_head.status;
   assign rsp_rx_fill = rsp_head.rx_fill;
   assign rsp_tx_fill = rsp_head.tx_fill;

   // slot counters never run past their queue depth
   a_front_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      front_cnt_ff <= cfc_pkg::MID_CNT_W'(cfc_pkg::MID_DEPTH))
      else $error("front slot count above middle queue depth");

   a_back_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      back_cnt_ff <= cfc_pkg::RSP_CNT_W'(cfc_pkg::RSP_DEPTH))
      else $error("back slot count above result queue depth");

   // a word leaves the middle queue only when one is there
   a_mid_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      mid_pop |-> !mid_empty && front_cnt_ff != '0)
      else $error("middle queue popped with no word counted");

   // a fill lands on one side only, and only with an ok status
   a_fill_one_side: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_rx_fill == 16'd0 || rsp_tx_fill == 16'd0) &&
                 (rsp_status == cfc_pkg::STATUS_OK ||
                  (rsp_rx_fill == 16'd0 && rsp_tx_fill == 16'd0)))
      else $error("result fill on both sides or with error status");

   // only defined status codes reach the result ports
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      !empty |-> (rsp_status == cfc_pkg::STATUS_OK ||
                  rsp_status == cfc_pkg::STATUS_INVALID ||
                  rsp_status == cfc_pkg::STATUS_OVERFLOW))
      else $error("reserved status code on result word");

endmodule
`default_nettype wire

>>> verif/csi_fifo_fill_calc_tb.sv
// csi_fifo_fill_calc_tb: checks the csi fifo fill block against its own predictor
// depends on cfc_pkg and csi_fifo_fill_calc
`timescale 1ns / 1ps
`default_nettype none
module csi_fifo_fill_calc_tb;

   typedef struct {
      logic [12:0] rate;
      logic [3:0]  lanes;
      logic [5:0]  bpp;
      logic [15:0] line;
      logic [9:0]  pclk;
   } link_cfg_type;

   typedef struct {
      cfc_pkg::status_type status;
      logic [15:0]         rx_fill;
      logic [15:0]         tx_fill;
   } fill_word_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        pop = 1'b0;
   logic [12:0] req_lane_bitrate_mhz = '0;
   logic [3:0]  req_lane_count = '0;
   logic [5:0]  req_bits_per_pixel = '0;
   logic [15:0] req_line_pixels = '0;
   logic [9:0]  req_pixel_clock_mhz = '0;
   logic        full, empty;
   logic [1:0]  rsp_status;
   logic [15:0] rsp_rx_fill, rsp_tx_fill;

   link_cfg_type  pending_cfgs[$];
   fill_word_type expected_fills[$];
   int            fail_count = 0;
   bit            stim_done = 1'b0;
   bit            sender_hold = 1'b0;
   bit            long_stall = 1'b0;
   int            burst_left = 0;
   int            gap_left = 0;
   int            stall_left = 0;

   csi_fifo_fill_calc dut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_lane_bitrate_mhz(req_lane_bitrate_mhz), .req_lane_count(req_lane_count),
      .req_bits_per_pixel(req_bits_per_pixel), .req_line_pixels(req_line_pixels),
      .req_pixel_clock_mhz(req_pixel_clock_mhz), .empty(empty), .pop(pop),
      .rsp_status(rsp_status), .rsp_rx_fill(rsp_rx_fill), .rsp_tx_fill(rsp_tx_fill)
   );

   always #10 clock = ~clock;

   // fill level predicted from one link configuration
   function automatic fill_word_type predict_fill(link_cfg_type c);
      fill_word_type r;
      longint unsigned bclk, unit, d, a, q, pos, neg, mag, den, fill;
      bit positive;
      r.status = cfc_pkg::STATUS_OK;
      r.rx_fill = '0;
      r.tx_fill = '0;
      bclk = c.rate / 8;
      unit = c.bpp / 2;
      if (c.lanes == 0 || c.pclk == 0 || bclk == 0 || unit == 0) begin
         r.status = cfc_pkg::STATUS_INVALID;
         return r;
      end
      d = c.lanes * bclk;
      a = cfc_pkg::HDR_BYTES + (longint'(c.line) * c.bpp) / 8 + cfc_pkg::FTR_BYTES;
      q = cfc_pkg::PRELOAD_BASE + (cfc_pkg::PRELOAD_N * 4) / c.lanes;
      pos = a * cfc_pkg::FRAC_SCALE * c.pclk + cfc_pkg::FRAC_OFFSET * d * c.pclk;
      neg = (c.line + q) * cfc_pkg::FRAC_SCALE * d;
      positive = pos > neg;
      mag = positive ? pos - neg : neg - pos;
      den = cfc_pkg::FRAC_SCALE * d * c.pclk * 4 * unit;
      fill = ((mag * bclk * c.lanes + den - 1) / den) * unit;
      if (fill > 64'hFFFF) r.status = cfc_pkg::STATUS_OVERFLOW;
      else if (positive) r.rx_fill = fill[15:0];
      else r.tx_fill = fill[15:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t: %s", $realtime, what);
      fail_count++;
   endtask

   function automatic link_cfg_type rand_cfg();
      link_cfg_type c;
      c.rate  = 13'($urandom);
      c.lanes = 4'($urandom);
      c.bpp   = 6'($urandom);
      c.line  = 16'($urandom);
      c.pclk  = 10'($urandom);
      // mostly realistic links so the fill lands in range
      if ($urandom_range(0, 3) != 0) begin
         c.rate  = 13'($urandom_range(80, 8191));
         c.lanes = 4'($urandom_range(1, 15));
         c.bpp   = 6'($urandom_range(2, 63));
         c.line  = 16'($urandom_range(0, 8000));
         c.pclk  = 10'($urandom_range(1, 1023));
      end
      return c;
   endfunction

   function automatic link_cfg_type mk(int r, int l, int b, int p, int k);
      link_cfg_type c;
      c.rate = 13'(r); c.lanes = 4'(l); c.bpp = 6'(b); c.line = 16'(p); c.pclk = 10'(k);
      return c;
   endfunction

   // stimulus: directed corners, then random bursts
   initial begin
      pending_cfgs.push_back(mk(0, 0, 0, 0, 0));
      pending_cfgs.push_back(mk(8191, 15, 63, 65535, 1023));
      pending_cfgs.push_back(mk(7, 4, 10, 1920, 100));
      pending_cfgs.push_back(mk(800, 0, 10, 1920, 100));
      pending_cfgs.push_back(mk(800, 2, 10, 1920, 0));
      pending_cfgs.push_back(mk(800, 2, 1, 1920, 100));
      pending_cfgs.push_back(mk(8, 1, 2, 0, 1));
      pending_cfgs.push_back(mk(8191, 1, 63, 65535, 1));
      pending_cfgs.push_back(mk(8, 15, 2, 65535, 1023));
      pending_cfgs.push_back(mk(912, 2, 10, 3280, 180));
      pending_cfgs.push_back(mk(456, 2, 8, 640, 24));
      pending_cfgs.push_back(mk(1600, 4, 12, 4000, 400));
      pending_cfgs.push_back(mk(8191, 15, 2, 1, 1023));
      pending_cfgs.push_back(mk(5461, 10, 42, 43690, 682));
      pending_cfgs.push_back(mk(2730, 5, 21, 21845, 341));
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < 500; i++) pending_cfgs.push_back(rand_cfg());
      wait (pending_cfgs.size() == 0);
      // sender pause until everything drains
      sender_hold = 1'b1;
      wait (expected_fills.size() == 0);
      sender_hold = 1'b0;
      for (int i = 0; i < 600; i++) pending_cfgs.push_back(rand_cfg());
      wait (pending_cfgs.size() < 400);
      // long receiver hold-off while the sender keeps pushing
      long_stall = 1'b1;
      repeat (200) @(posedge clock);
      long_stall = 1'b0;
      wait (pending_cfgs.size() == 0);
      stim_done = 1'b1;
   end

   // driver: bursts and gaps
   always @(posedge clock) begin
      link_cfg_type c;
      if (push && !full && !reset) begin
         expected_fills.push_back(predict_fill(pending_cfgs.pop_front()));
      end
      if (reset || sender_hold || pending_cfgs.size() == 0 ||
          (push && !full && pending_cfgs.size() == 0)) begin
         push <= 1'b0;
      end else if (push && full) begin
         push <= 1'b1;
      end else if (gap_left > 0) begin
         gap_left--;
         push <= 1'b0;
      end else begin
         if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
         end
         burst_left--;
         c = pending_cfgs[0];
         push <= 1'b1;
         req_lane_bitrate_mhz <= c.rate;
         req_lane_count <= c.lanes;
         req_bits_per_pixel <= c.bpp;
         req_line_pixels <= c.line;
         req_pixel_clock_mhz <= c.pclk;
      end
   end

   // monitor: pop pattern and result check
   always @(posedge clock) begin
      fill_word_type e;
      if (!reset && pop && !empty) begin
         if (expected_fills.size() == 0) begin
            report_mismatch("result with no expectation");
         end else begin
            e = expected_fills.pop_front();
            if (rsp_status !== e.status)
               report_mismatch($sformatf("status %0d exp %0d", rsp_status, e.status));
            if (rsp_rx_fill !== e.rx_fill)
               report_mismatch($sformatf("rx_fill %0d exp %0d", rsp_rx_fill, e.rx_fill));
            if (rsp_tx_fill !== e.tx_fill)
               report_mismatch($sformatf("tx_fill %0d exp %0d", rsp_tx_fill, e.tx_fill));
         end
      end
      if (stall_left > 0) begin
         stall_left--;
         pop <= 1'b0;
      end else if (long_stall) begin
         pop <= 1'b0;
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left = $urandom_range(1, 12);
         pop <= 1'b0;
      end else begin
         pop <= 1'b1;
      end
   end

   // end of run
   initial begin
      wait (stim_done);
      wait (expected_fills.size() == 0);
      repeat (60) @(posedge clock);
      if (fail_count == 0 && expected_fills.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end
endmodule
`default_nettype wire

>>> files.f
src/cfc_pkg.sv
src/cfc_front.sv
src/cfc_mid_queue.sv
src/cfc_back.sv
src/cfc_rsp_queue.sv
src/csi_fifo_fill_calc.sv
verif/csi_fifo_fill_calc_tb.sv
